// ===== rtl/one_wire_bus_master_assert.svh =====
// Assertion macros for the one-wire bus master checker.
// Each macro expands to one labeled concurrent assertion clocked on clk.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/owm_pkg.sv =====
// Shared types, codes and constants for the one-wire bus master.
// Used by the sequencer and the top level; depends on nothing else.
`default_nettype none

package owm_pkg;

    // Width of the phase timer; durations above its range saturate.
    localparam int TIMER_WIDTH = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int BITS_W      = 4;

    localparam logic [31:0]            TIMER_TOP32 = (32'd1 << TIMER_WIDTH) - 32'd1;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX   = TIMER_TOP32[TIMER_WIDTH-1:0];
    localparam logic [TIMER_WIDTH-1:0] TIMER_ONE   = TIMER_WIDTH'(1);

    localparam logic [BITS_W-1:0] BITS_PER_BYTE = BITS_W'(8);
    localparam logic [BITS_W-1:0] BITS_ONE      = BITS_W'(1);

    // Register defaults after reset.
    localparam logic [11:0] RESET_LOW_DEFAULT     = 12'd500;
    localparam logic [9:0]  PRESENCE_WAIT_DEFAULT = 10'd70;
    localparam logic [7:0]  SLOT_LOW_DEFAULT      = 8'd6;
    localparam logic [7:0]  SAMPLE_WAIT_DEFAULT   = 8'd9;
    localparam logic [7:0]  HOLD_DEFAULT          = 8'd45;
    localparam logic [7:0]  RECOVERY_DEFAULT      = 8'd10;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_LOW      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_WAIT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD          = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY      = 3'd5;

    // Reset status codes.
    localparam logic [1:0] ST_PRESENT   = 2'd0;
    localparam logic [1:0] ST_NO_DEVICE = 2'd1;
    localparam logic [1:0] ST_SHORTED   = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_RESET  = 3'd1,
        CMD_BYTE   = 3'd2,
        CMD_BIT    = 3'd3,
        CMD_PU_ON  = 3'd4,
        CMD_PU_OFF = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_PRES,
        PH_RST_SHORT,
        PH_SLOT_LOW,
        PH_SLOT_SAMPLE,
        PH_SLOT_HOLD,
        PH_SLOT_RECOVER
    } phase_t;

    typedef struct packed {
        logic [11:0] reset_low;
        logic [9:0]  presence_wait;
        logic [7:0]  slot_low;
        logic [7:0]  sample_wait;
        logic [7:0]  hold;
        logic [7:0]  recovery;
    } owm_cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       strong_pullup;
        logic       busy;
        logic       done;
        logic [7:0] rx_data;
        logic [1:0] status;
    } owm_res_t;

    // Phase duration: zero counts as one tick, large values saturate.
    function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [CFG_DATA_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (v == '0)
            return TIMER_ONE;
        else if (wide > TIMER_TOP32)
            return TIMER_MAX;
        else
            return wide[TIMER_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/owm_seq.sv =====
// Tick sequencer for the one-wire bus master: phase, timer and shift state.
// Depends on owm_pkg; advances one tick on each step and gives that tick's result.
`default_nettype none

module owm_seq
    import owm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [2:0] cmd,
    input  wire logic [7:0] tx_data,
    input  wire logic       bus_level,
    input  wire owm_cfg_t   cfg,
    output owm_res_t        res
);

    phase_t                  phase_reg, phase_next, phase_a;
    logic [TIMER_WIDTH-1:0]  timer_reg, timer_next, timer_a, timer_dec;
    logic [7:0]              shift_reg, shift_next, shift_a;
    logic [BITS_W-1:0]       bits_reg, bits_next, bits_a, bits_dec;
    logic                    mode_reg, mode_next, mode_a;
    logic                    sampled_reg, sampled_next;
    logic [1:0]              status_reg, status_next;
    logic                    pullup_reg, pullup_next;
    logic                    drive, busy, done, done_a, tx_bit;

    // Command decode on an idle tick; a started sequence runs its first phase
    // in the same tick.
    always_comb
    begin
        phase_a     = phase_reg;
        timer_a     = timer_reg;
        shift_a     = shift_reg;
        bits_a      = bits_reg;
        mode_a      = mode_reg;
        pullup_next = pullup_reg;
        done_a      = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            case (cmd)
                CMD_RESET:
                begin
                    pullup_next = 1'b0;
                    phase_a     = PH_RST_LOW;
                    timer_a     = timer_load(cfg.reset_low);
                end
                CMD_BYTE:
                begin
                    pullup_next = 1'b0;
                    mode_a      = 1'b1;
                    shift_a     = tx_data;
                    bits_a      = BITS_PER_BYTE;
                    phase_a     = PH_SLOT_LOW;
                    timer_a     = timer_load(CFG_DATA_W'(cfg.slot_low));
                end
                CMD_BIT:
                begin
                    pullup_next = 1'b0;
                    mode_a      = 1'b0;
                    shift_a     = {7'd0, tx_data[0]};
                    bits_a      = BITS_ONE;
                    phase_a     = PH_SLOT_LOW;
                    timer_a     = timer_load(CFG_DATA_W'(cfg.slot_low));
                end
                CMD_PU_ON:
                begin
                    pullup_next = 1'b1;
                    done_a      = 1'b1;
                end
                CMD_PU_OFF:
                begin
                    pullup_next = 1'b0;
                    done_a      = 1'b1;
                end
                default:
                begin
                    pullup_next = pullup_reg;
                end
            endcase
        end
    end

    // Phase timing: count down, and move on when the count runs out.
    always_comb
    begin
        phase_next   = phase_a;
        timer_next   = timer_a;
        shift_next   = shift_a;
        bits_next    = bits_a;
        mode_next    = mode_a;
        sampled_next = sampled_reg;
        status_next  = status_reg;
        done         = done_a;
        busy         = 1'b0;
        drive        = 1'b0;
        tx_bit       = shift_a[0];
        timer_dec    = timer_a - TIMER_ONE;
        bits_dec     = bits_a - BITS_ONE;
        if (phase_a != PH_IDLE)
        begin
            busy       = 1'b1;
            timer_next = timer_dec;
            case (phase_a)
                PH_RST_LOW, PH_SLOT_LOW:       drive = 1'b1;
                PH_SLOT_SAMPLE, PH_SLOT_HOLD:  drive = ~tx_bit;
                default:                       drive = 1'b0;
            endcase
            if (timer_dec == '0)
            begin
                case (phase_a)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_PRES;
                        timer_next = timer_load(CFG_DATA_W'(cfg.presence_wait));
                    end
                    PH_RST_PRES:
                    begin
                        status_next = bus_level ? ST_NO_DEVICE : ST_PRESENT;
                        phase_next  = PH_RST_SHORT;
                        timer_next  = timer_load(CFG_DATA_W'(cfg.presence_wait));
                    end
                    PH_RST_SHORT:
                    begin
                        if (!bus_level)
                            status_next = ST_SHORTED;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_SLOT_LOW:
                    begin
                        phase_next = PH_SLOT_SAMPLE;
                        timer_next = timer_load(CFG_DATA_W'(cfg.sample_wait));
                    end
                    PH_SLOT_SAMPLE:
                    begin
                        sampled_next = tx_bit & bus_level;
                        phase_next   = PH_SLOT_HOLD;
                        timer_next   = timer_load(CFG_DATA_W'(cfg.hold));
                    end
                    PH_SLOT_HOLD:
                    begin
                        phase_next = PH_SLOT_RECOVER;
                        timer_next = timer_load(CFG_DATA_W'(cfg.recovery));
                    end
                    PH_SLOT_RECOVER:
                    begin
                        // Shift the sampled bit in at the top, LSB first.
                        shift_next = {sampled_reg, shift_a[7:1]};
                        bits_next  = bits_dec;
                        if (bits_dec == '0)
                        begin
                            if (!mode_a)
                                shift_next = {7'd0, sampled_reg};
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_SLOT_LOW;
                            timer_next = timer_load(CFG_DATA_W'(cfg.slot_low));
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Result of this tick.
    always_comb
    begin
        res.drive_low     = drive;
        res.strong_pullup = drive ? 1'b0 : pullup_next;
        res.busy          = busy;
        res.done          = done;
        res.rx_data       = shift_next;
        res.status        = status_next;
    end

    // Sequencer state, advanced once per transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            timer_reg   <= '0;
            shift_reg   <= '0;
            bits_reg    <= '0;
            mode_reg    <= 1'b0;
            sampled_reg <= 1'b0;
            status_reg  <= ST_PRESENT;
            pullup_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            shift_reg   <= shift_next;
            bits_reg    <= bits_next;
            mode_reg    <= mode_next;
            sampled_reg <= sampled_next;
            status_reg  <= status_next;
            pullup_reg  <= pullup_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/one_wire_bus_master.sv =====
// One-wire bus master: one input item per bus tick, one result per item.
// Latency: the result of an item is presented in the cycle after its transfer.
// Throughput: one item per cycle, out_ready permitting; output refills while read.
// Reset: asynchronous, active low; idle phase, pull-up off, registers at defaults.
// Depends on owm_pkg and owm_seq.
`default_nettype none

module one_wire_bus_master
    import owm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [2:0]             cmd,
    input  wire logic [7:0]             tx_data,
    input  wire logic                   bus_level,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        drive_low,
    output logic                        strong_pullup,
    output logic                        busy_res,
    output logic                        done_res,
    output logic [7:0]                  rx_data,
    output logic [1:0]                  reset_status,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    owm_cfg_t cfg_reg;
    owm_res_t res, res_reg;
    logic     out_valid_reg;
    logic     in_xfer;

    assign cfg_ready = 1'b1;
    assign in_ready  = ~out_valid_reg | out_ready;
    assign in_xfer   = in_valid & in_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low     <= RESET_LOW_DEFAULT;
            cfg_reg.presence_wait <= PRESENCE_WAIT_DEFAULT;
            cfg_reg.slot_low      <= SLOT_LOW_DEFAULT;
            cfg_reg.sample_wait   <= SAMPLE_WAIT_DEFAULT;
            cfg_reg.hold          <= HOLD_DEFAULT;
            cfg_reg.recovery      <= RECOVERY_DEFAULT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RESET_LOW:     cfg_reg.reset_low     <= cfg_data;
                REG_PRESENCE_WAIT: cfg_reg.presence_wait <= cfg_data[9:0];
                REG_SLOT_LOW:      cfg_reg.slot_low      <= cfg_data[7:0];
                REG_SAMPLE_WAIT:   cfg_reg.sample_wait   <= cfg_data[7:0];
                REG_HOLD:          cfg_reg.hold          <= cfg_data[7:0];
                REG_RECOVERY:      cfg_reg.recovery      <= cfg_data[7:0];
                default:           cfg_reg.reset_low     <= cfg_reg.reset_low;
            endcase
        end
    end

    owm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_xfer),
        .cmd       (cmd),
        .tx_data   (tx_data),
        .bus_level (bus_level),
        .cfg       (cfg_reg),
        .res       (res)
    );

    // Output register: loads on every input transfer, empties when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            res_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign drive_low     = res_reg.drive_low;
    assign strong_pullup = res_reg.strong_pullup;
    assign busy_res      = res_reg.busy;
    assign done_res      = res_reg.done;
    assign rx_data       = res_reg.rx_data;
    assign reset_status  = res_reg.status;

endmodule

`default_nettype wire

// ===== rtl/owm_checker.sv =====
// Port-level checks for the one-wire bus master, attached by bind.
// Depends on one_wire_bus_master_assert.svh for the assertion macros.
`default_nettype none

`include "one_wire_bus_master_assert.svh"

module owm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       drive_low,
    input wire logic       strong_pullup,
    input wire logic       busy_res,
    input wire logic       done_res,
    input wire logic [7:0] rx_data,
    input wire logic [1:0] reset_status
);

    // The line is never pulled low and driven high in the same tick.
    `OWM_ASSERT_NOW(a_no_contention, out_valid, !(drive_low && strong_pullup), "bus contention")

    // Driving low only happens inside a reset or slot sequence.
    `OWM_ASSERT_NOW(a_drive_in_seq, out_valid && drive_low, busy_res, "drive outside sequence")

    // With the output register empty, a new transfer is always possible.
    `OWM_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "stalled while empty")

    // A stalled result holds its value.
    `OWM_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready,
        out_valid && $stable(rx_data) && $stable(reset_status) && $stable(done_res),
        "stalled result changed")

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (.*);

`default_nettype wire

// ===== tb/one_wire_bus_master_checker.sv =====
`timescale 1ns / 100ps
// Transaction checker for the one-wire bus master: predicts each tick result and compares it.
// Depends on owm_pkg for the command codes, phase names and register indexes.
module one_wire_bus_master_checker
    import owm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic [2:0]             cmd,
    input  wire logic [7:0]             tx_data,
    input  wire logic                   bus_level,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic                   drive_low,
    input  wire logic                   strong_pullup,
    input  wire logic                   busy_res,
    input  wire logic                   done_res,
    input  wire logic [7:0]             rx_data,
    input  wire logic [1:0]             reset_status,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          fail_count,
    output int                          pending,
    output logic                        seq_busy
);

    localparam int TICK_TOP = (1 << TIMER_WIDTH) - 1;

    // Predicted sequencer state and timing registers.
    owm_cfg_t                 timing;
    phase_t                   phase;
    logic [TIMER_WIDTH-1:0]   ticks_left;
    logic [7:0]               shifter;
    logic [BITS_W-1:0]        slots_left;
    logic                     whole_byte;
    logic                     last_sample;
    logic [1:0]               line_status;
    logic                     pullup_on;
    owm_res_t                 expected_ticks[$];

    // A zero duration lasts one tick; anything beyond the timer range saturates.
    function automatic logic [TIMER_WIDTH-1:0] phase_len(input int unsigned v);
        if (v == 0)
            return TIMER_WIDTH'(1);
        if (v > TICK_TOP)
            return TIMER_WIDTH'(TICK_TOP);
        return TIMER_WIDTH'(v);
    endfunction

    task automatic start_phase(input phase_t p, input int unsigned span);
        phase = p;
        ticks_left = phase_len(span);
    endtask

    // Advance the predicted sequencer by one bus tick and queue the result it gives.
    task automatic predict_bus_tick(input logic [2:0] c, input logic [7:0] d, input logic lvl);
        owm_res_t r;
        logic     lsb;
        r = '0;
        if (phase == PH_IDLE) begin
            case (c)
                CMD_RESET:
                begin
                    pullup_on = 1'b0;
                    start_phase(PH_RST_LOW, timing.reset_low);
                end
                CMD_BYTE, CMD_BIT:
                begin
                    pullup_on = 1'b0;
                    whole_byte = (c == CMD_BYTE);
                    shifter = whole_byte ? d : {7'b0, d[0]};
                    slots_left = whole_byte ? BITS_PER_BYTE : BITS_ONE;
                    start_phase(PH_SLOT_LOW, timing.slot_low);
                end
                CMD_PU_ON:
                begin
                    pullup_on = 1'b1;
                    r.done = 1'b1;
                end
                CMD_PU_OFF:
                begin
                    pullup_on = 1'b0;
                    r.done = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (phase != PH_IDLE) begin
            lsb = shifter[0];
            r.busy = 1'b1;
            case (phase)
                PH_RST_LOW, PH_SLOT_LOW: r.drive_low = 1'b1;
                PH_SLOT_SAMPLE, PH_SLOT_HOLD: r.drive_low = !lsb;
                default: r.drive_low = 1'b0;
            endcase
            ticks_left = ticks_left - 1'b1;
            if (ticks_left == '0) begin
                case (phase)
                    PH_RST_LOW: start_phase(PH_RST_PRES, timing.presence_wait);
                    PH_RST_PRES:
                    begin
                        line_status = lvl ? ST_NO_DEVICE : ST_PRESENT;
                        start_phase(PH_RST_SHORT, timing.presence_wait);
                    end
                    PH_RST_SHORT:
                    begin
                        // A line still low after the second wait means a short.
                        if (!lvl)
                            line_status = ST_SHORTED;
                        phase = PH_IDLE;
                        r.done = 1'b1;
                    end
                    PH_SLOT_LOW: start_phase(PH_SLOT_SAMPLE, timing.sample_wait);
                    PH_SLOT_SAMPLE:
                    begin
                        last_sample = lsb & lvl;
                        start_phase(PH_SLOT_HOLD, timing.hold);
                    end
                    PH_SLOT_HOLD: start_phase(PH_SLOT_RECOVER, timing.recovery);
                    default:
                    begin
                        // End of a slot: shift the sampled bit in from the top.
                        shifter = {last_sample, shifter[7:1]};
                        slots_left = slots_left - 1'b1;
                        if (slots_left == '0) begin
                            if (!whole_byte)
                                shifter = {7'b0, last_sample};
                            phase = PH_IDLE;
                            r.done = 1'b1;
                        end
                        else begin
                            start_phase(PH_SLOT_LOW, timing.slot_low);
                        end
                    end
                endcase
            end
        end

        r.strong_pullup = r.drive_low ? 1'b0 : pullup_on;
        r.rx_data = shifter;
        r.status = line_status;
        expected_ticks.push_back(r);
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Register writes, result comparison and prediction, all at the transfer edge.
    always @(posedge clk or negedge rst_n) begin
        owm_res_t want;
        if (!rst_n) begin
            timing = '{reset_low: RESET_LOW_DEFAULT, presence_wait: PRESENCE_WAIT_DEFAULT,
                       slot_low: SLOT_LOW_DEFAULT, sample_wait: SAMPLE_WAIT_DEFAULT,
                       hold: HOLD_DEFAULT, recovery: RECOVERY_DEFAULT};
            phase = PH_IDLE;
            ticks_left = '0;
            shifter = '0;
            slots_left = '0;
            whole_byte = 1'b0;
            last_sample = 1'b0;
            line_status = ST_PRESENT;
            pullup_on = 1'b0;
            expected_ticks.delete();
            fail_count = 0;
            pending <= 0;
            seq_busy <= 1'b0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RESET_LOW: timing.reset_low = cfg_data[11:0];
                    REG_PRESENCE_WAIT: timing.presence_wait = cfg_data[9:0];
                    REG_SLOT_LOW: timing.slot_low = cfg_data[7:0];
                    REG_SAMPLE_WAIT: timing.sample_wait = cfg_data[7:0];
                    REG_HOLD: timing.hold = cfg_data[7:0];
                    REG_RECOVERY: timing.recovery = cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid && out_ready) begin
                if (expected_ticks.size() == 0) begin
                    $display("%0t ns: result transfer with nothing expected", $time);
                    fail_count++;
                end
                else begin
                    want = expected_ticks.pop_front();
                    check_field("drive_low", want.drive_low, drive_low);
                    check_field("strong_pullup", want.strong_pullup, strong_pullup);
                    check_field("busy_res", want.busy, busy_res);
                    check_field("done_res", want.done, done_res);
                    check_field("rx_data", want.rx_data, rx_data);
                    check_field("reset_status", want.status, reset_status);
                end
            end

            if (in_valid && in_ready)
                predict_bus_tick(cmd, tx_data, bus_level);

            pending <= expected_ticks.size();
            seq_busy <= (phase != PH_IDLE);
        end
    end

endmodule

// ===== tb/one_wire_bus_master_tb.sv =====
`timescale 1ns / 100ps
// Top of the one-wire bus master testbench: clock, reset, stimulus and the verdict.
// Depends on owm_pkg, the block itself and one_wire_bus_master_checker.
module one_wire_bus_master_tb;
    import owm_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int RANDOM_TICKS    = 225;

    // Codes outside the defined sets, which the block must ignore.
    localparam logic [2:0]             CMD_SPARE_A = 3'd6;
    localparam logic [2:0]             CMD_SPARE_B = 3'd7;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = REG_RECOVERY + 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = REG_RECOVERY + 3'd2;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [2:0]             cmd;
    logic [7:0]             tx_data;
    logic                   bus_level;
    logic                   out_valid;
    logic                   out_ready;
    logic                   drive_low;
    logic                   strong_pullup;
    logic                   busy_res;
    logic                   done_res;
    logic [7:0]             rx_data;
    logic [1:0]             reset_status;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int       fail_count;
    int       pending;
    logic     seq_busy;
    int       stalled_cycles = 0;
    int       send_idle_pct = 14;
    int       recv_idle_pct = 81;
    bit       pressure_on = 1'b0;
    owm_cfg_t timing;

    one_wire_bus_master dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .tx_data       (tx_data),
        .bus_level     (bus_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive_low     (drive_low),
        .strong_pullup (strong_pullup),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .rx_data       (rx_data),
        .reset_status  (reset_status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    one_wire_bus_master_checker bus_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .tx_data       (tx_data),
        .bus_level     (bus_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive_low     (drive_low),
        .strong_pullup (strong_pullup),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .rx_data       (rx_data),
        .reset_status  (reset_status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .seq_busy      (seq_busy)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Count cycles in which no channel completes a transfer.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial begin
        wait (stalled_cycles >= STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off once pressure is requested.
    initial begin : result_sink
        bit held_off = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (pressure_on && !held_off) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                held_off = 1'b1;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic int dur(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    // Offer one bus tick, with an optional random gap first, and wait for its transfer.
    task automatic send_tick(input logic [2:0] c, input logic [7:0] d, input logic lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        tx_data <= d;
        bus_level <= lvl;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Issue one command and exactly enough ticks to finish it. The line reads lvl_a up to
    // tick split and lvl_b after it; the second tick carries a command that must be ignored.
    task automatic run_cmd(input logic [2:0] c, input logic [7:0] d, input logic lvl_a,
                           input logic lvl_b, input int split, input logic [2:0] intrude);
        int span;
        int slot;
        slot = dur(timing.slot_low) + dur(timing.sample_wait) + dur(timing.hold)
             + dur(timing.recovery);
        case (c)
            CMD_RESET: span = dur(timing.reset_low) + 2 * dur(timing.presence_wait);
            CMD_BYTE: span = int'(BITS_PER_BYTE) * slot;
            CMD_BIT: span = slot;
            default: span = 1;
        endcase
        for (int i = 1; i <= span; i++)
            send_tick((i == 1) ? c : ((i == 2) ? intrude : CMD_NONE), 8'($urandom),
                      (i <= split) ? lvl_a : lvl_b);
    endtask

    // Bring the sequencer to idle and wait for every outstanding result.
    task automatic settle();
        forever begin
            in_valid <= 1'b0;
            @(posedge clk);
            wait (pending == 0);
            if (!seq_busy)
                break;
            while (seq_busy)
                send_tick(CMD_NONE, 8'($urandom), 1'($urandom));
        end
        repeat (4) @(posedge clk);
    endtask

    // Write all six timing registers, optionally also the two spare indexes.
    task automatic program_timing(input owm_cfg_t t, input bit poke_spare);
        logic [CFG_INDEX_W-1:0] idx[8];
        logic [CFG_DATA_W-1:0]  val[8];
        int                     n;
        idx[0] = REG_RESET_LOW;     val[0] = t.reset_low;
        idx[1] = REG_PRESENCE_WAIT; val[1] = CFG_DATA_W'(t.presence_wait);
        idx[2] = REG_SLOT_LOW;      val[2] = CFG_DATA_W'(t.slot_low);
        idx[3] = REG_SAMPLE_WAIT;   val[3] = CFG_DATA_W'(t.sample_wait);
        idx[4] = REG_HOLD;          val[4] = CFG_DATA_W'(t.hold);
        idx[5] = REG_RECOVERY;      val[5] = CFG_DATA_W'(t.recovery);
        idx[6] = REG_SPARE_A;       val[6] = '1;
        idx[7] = REG_SPARE_B;       val[7] = CFG_DATA_W'($urandom);
        n = poke_spare ? 8 : 6;
        for (int i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        timing = t;
    endtask

    task automatic random_run(input int count);
        logic [2:0] c;
        repeat (count) begin
            c = ($urandom_range(99) < 12) ? 3'($urandom_range(7, 1)) : CMD_NONE;
            send_tick(c, 8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        owm_cfg_t t;
        int       split;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        cmd <= CMD_NONE;
        tx_data <= '0;
        bus_level <= 1'b1;
        cfg_valid <= 1'b0;
        cfg_index <= REG_RESET_LOW;
        cfg_data <= '0;
        timing = '{reset_low: RESET_LOW_DEFAULT, presence_wait: PRESENCE_WAIT_DEFAULT,
                   slot_low: SLOT_LOW_DEFAULT, sample_wait: SAMPLE_WAIT_DEFAULT,
                   hold: HOLD_DEFAULT, recovery: RECOVERY_DEFAULT};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults after reset: one bit slot and a reset with a presence pulse.
        run_cmd(CMD_BIT, 8'h01, 1'b1, 1'b1, 0, CMD_NONE);
        split = dur(timing.reset_low) + dur(timing.presence_wait);
        run_cmd(CMD_RESET, 8'h00, 1'b0, 1'b1, split, CMD_NONE);
        settle();

        // Shortest timing, with zero durations that must count as one tick.
        program_timing('{reset_low: 12'd0, presence_wait: 10'd1, slot_low: 8'd0,
                         sample_wait: 8'd1, hold: 8'd0, recovery: 8'd1}, 1'b1);
        split = dur(timing.reset_low) + dur(timing.presence_wait);
        run_cmd(CMD_NONE, 8'hFF, 1'b0, 1'b0, 0, CMD_NONE);
        run_cmd(CMD_PU_ON, 8'h00, 1'b1, 1'b1, 0, CMD_NONE);
        run_cmd(CMD_NONE, 8'h00, 1'b1, 1'b1, 0, CMD_NONE);
        run_cmd(CMD_PU_OFF, 8'h00, 1'b1, 1'b1, 0, CMD_NONE);
        run_cmd(CMD_PU_ON, 8'h00, 1'b1, 1'b1, 0, CMD_NONE);
        run_cmd(CMD_BYTE, 8'hA5, 1'b1, 1'b1, 0, CMD_RESET);
        run_cmd(CMD_BYTE, 8'hFF, 1'b0, 1'b0, 0, CMD_NONE);
        run_cmd(CMD_BYTE, 8'hFF, 1'b1, 1'b1, 0, CMD_PU_ON);
        run_cmd(CMD_BYTE, 8'h00, 1'b1, 1'b1, 0, CMD_NONE);
        run_cmd(CMD_BIT, 8'h01, 1'b0, 1'b0, 0, CMD_NONE);
        run_cmd(CMD_BIT, 8'hFF, 1'b1, 1'b1, 0, CMD_BYTE);
        run_cmd(CMD_BIT, 8'hFE, 1'b1, 1'b1, 0, CMD_NONE);
        run_cmd(CMD_PU_ON, 8'h00, 1'b1, 1'b1, 0, CMD_NONE);
        run_cmd(CMD_RESET, 8'h00, 1'b0, 1'b1, split, CMD_PU_ON);
        run_cmd(CMD_RESET, 8'h00, 1'b1, 1'b1, split, CMD_NONE);
        run_cmd(CMD_RESET, 8'h00, 1'b0, 1'b0, split, CMD_NONE);
        run_cmd(CMD_RESET, 8'h00, 1'b1, 1'b0, split, CMD_BIT);
        run_cmd(CMD_SPARE_A, 8'hFF, 1'b1, 1'b1, 0, CMD_NONE);
        run_cmd(CMD_SPARE_B, 8'h00, 1'b0, 1'b0, 0, CMD_NONE);
        settle();

        // Random traffic under three idle patterns, each with fresh short timing.
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 14 : ((mode == 1) ? 81 : 0);
            recv_idle_pct = (mode == 0) ? 81 : ((mode == 1) ? 14 : 0);
            t.reset_low = 12'($urandom_range(24));
            t.presence_wait = 10'($urandom_range(10));
            t.slot_low = 8'($urandom_range(6));
            t.sample_wait = 8'($urandom_range(6));
            t.hold = 8'($urandom_range(8));
            t.recovery = 8'($urandom_range(4));
            program_timing(t, 1'b0);
            pressure_on = (mode == 2);
            random_run(RANDOM_TICKS);
            settle();
        end

        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
